/* rtl/packet_fifo_with_lifetime_drop_top_assert.svh */
// Assertion macros shared by the packet queue RTL.
// Each macro takes a label, clock, active-low reset, antecedent, consequent
// and message text.
`ifndef PACKET_FIFO_WITH_LIFETIME_DROP_TOP_ASSERT_SVH
`define PACKET_FIFO_WITH_LIFETIME_DROP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pfld_pkg.sv */
// ----------------------------------------------------------------------------
// pfld_pkg
// Types, constants and helper functions of the packet queue with lifetime drop.
// ----------------------------------------------------------------------------
package pfld_pkg;

    localparam int QUEUE_SLOTS    = 16;
    localparam int PACKET_BYTES   = 32;
    localparam int MAX_RESULTS    = 32;
    localparam int PTR_W          = $clog2(QUEUE_SLOTS);
    localparam int OFF_W          = $clog2(PACKET_BYTES + 1);
    localparam int BADDR_W        = $clog2(QUEUE_SLOTS * PACKET_BYTES);
    localparam int CMP_W          = 7;
    localparam int OCC_W          = 4;
    localparam int PADDR_W        = 3;
    localparam logic [31:0] LIFETIME_RESET = 32'd1000000;

    // Register word index taken from paddr[2].
    localparam logic REG_LIFETIME = 1'b0;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [OFF_W-1:0]   t_off;
    typedef logic [BADDR_W-1:0] t_baddr;

    typedef struct packed {
        t_off        len;
        logic [31:0] birth;
    } t_meta;

    typedef struct packed {
        logic       we;
        t_baddr     waddr;
        logic [7:0] wdata;
        logic       re;
        t_baddr     raddr;
    } t_ram_req;

    function automatic t_ptr next_slot(t_ptr p);
        return (p == t_ptr'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic t_baddr byte_addr(t_ptr slot, t_off off);
        return BADDR_W'(int'(slot) * PACKET_BYTES + int'(off));
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(t_ptr wp, t_ptr rp);
        logic [PTR_W:0] d;
        if (wp >= rp) begin
            d = {1'b0, wp} - {1'b0, rp};
        end else begin
            d = {1'b0, wp} + (PTR_W + 1)'(QUEUE_SLOTS) - {1'b0, rp};
        end
        return OCC_W'(d);
    endfunction

endpackage

/* rtl/pfld_if.sv */
// ----------------------------------------------------------------------------
// pfld_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface pfld_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [5:0] read_length;

    modport source (output valid, opcode, data_byte, last_byte, read_length,
                    input ready);
    modport sink   (input valid, opcode, data_byte, last_byte, read_length,
                    output ready);
endinterface

interface pfld_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       has_data;
    logic [7:0] out_byte;
    logic       last;
    logic [3:0] occupancy;

    modport source (output valid, status, has_data, out_byte, last, occupancy,
                    input ready);
    modport sink   (input valid, status, has_data, out_byte, last, occupancy,
                    output ready);
endinterface

/* rtl/packet_fifo_with_lifetime_drop_top.sv */
// ----------------------------------------------------------------------------
// packet_fifo_with_lifetime_drop_top
// Circular packet queue with per-packet lifetime expiry.
// ----------------------------------------------------------------------------
// Command items arrive on i_in_ch: a tick advances the 32-bit time, a push
// writes one packet byte into the tail slot, a pop delivers the oldest live
// packet. Results leave on o_out_ch through a single output register.
// Ticks and non-final push bytes give no result. A final push byte passes
// through the result state and gives one status result. A pop is accepted,
// then examines head slots one at a time through the metadata memory read
// port, then delivers one byte per cycle from the byte memory while the
// output register is free, or a single status result when nothing is
// delivered. Expired packets at the head are discarded during that walk.
// Synchronous reset empties the queue, clears time and the tail offset and
// restores the lifetime register; the memories are not cleared.
// While the receiver stalls, the pending result is held and the sequencer
// waits; a new command is taken only once the previous item's results are
// all in or through the output register. The lifetime register is written
// through the APB port at byte address 0.
`include "packet_fifo_with_lifetime_drop_top_assert.svh"

module packet_fifo_with_lifetime_drop_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pfld_in_if.sink                      i_in_ch,
    pfld_out_if.source                   o_out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfld_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pfld_pkg::*;

    logic [31:0] lifetime;
    t_ram_req    ram_req;
    logic [7:0]  ram_rdata;

    pfld_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_lifetime (lifetime)
    );

    pfld_byte_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    pfld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lifetime  (lifetime),
        .i_in_ch     (i_in_ch),
        .o_out_ch    (o_out_ch),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    // An accepted pop always moves the sequencer out of idle, so ready drops.
    `PFLD_ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, i_in_ch.valid && i_in_ch.ready && (i_in_ch.opcode == OP_POP), !i_in_ch.ready, "pop accepted but ready stayed high")
    // A result without a data byte is always the only result of its item.
    `PFLD_ASSERT_NOW(a_nodata_last, i_clk, i_rst_n, o_out_ch.valid && !o_out_ch.has_data, o_out_ch.last && (o_out_ch.out_byte == 8'd0), "status result not marked last")
    // Full and empty reports never carry a byte.
    `PFLD_ASSERT_NOW(a_status_nodata, i_clk, i_rst_n, o_out_ch.valid && (o_out_ch.status != ST_OK), !o_out_ch.has_data, "error status with data byte")

endmodule

/* rtl/pfld_cfg.sv */
// ----------------------------------------------------------------------------
// pfld_cfg
// APB register file holding the packet lifetime.
// ----------------------------------------------------------------------------
module pfld_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfld_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [31:0]                 o_lifetime
);
    import pfld_pkg::*;

    logic [31:0] r_lifetime;
    logic        hit;

    assign hit = (paddr[2] == REG_LIFETIME) && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_lifetime <= pwdata;
        end
    end

    assign prdata     = hit ? r_lifetime : 32'd0;
    assign pready     = 1'b1;
    assign o_lifetime = r_lifetime;

endmodule

/* rtl/pfld_byte_ram.sv */
// ----------------------------------------------------------------------------
// pfld_byte_ram
// Packet byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfld_byte_ram (
    input  logic                i_clk,
    input  pfld_pkg::t_ram_req  i_req,
    output logic [7:0]          o_rdata
);
    import pfld_pkg::*;

    logic [7:0] mem [QUEUE_SLOTS * PACKET_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pfld_ctrl.sv */
// ----------------------------------------------------------------------------
// pfld_ctrl
// Queue sequencer: pointers, time, slot metadata store and result register.
// ----------------------------------------------------------------------------
module pfld_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_lifetime,
    pfld_in_if.sink            i_in_ch,
    pfld_out_if.source         o_out_ch,
    output pfld_pkg::t_ram_req o_ram_req,
    input  logic [7:0]         i_ram_rdata
);
    import pfld_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_BOUT, S_RESULT} t_state;

    t_state      r_state, n_state;
    t_ptr        r_rp, n_rp;
    t_ptr        r_wp, n_wp;
    t_ptr        r_slot, n_slot;
    t_off        r_off, n_off;
    t_off        r_cnt, n_cnt;
    t_off        r_n, n_n;
    logic [5:0]  r_req, n_req;
    logic [31:0] r_time, n_time;
    logic [1:0]  r_pend, n_pend;
    logic        r_ov, n_ov;
    logic [1:0]  r_status, n_status;
    logic        r_has, n_has;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic [OCC_W-1:0] r_occ, n_occ;

    // Slot metadata store: length and birth time per slot.
    t_meta       meta_mem [QUEUE_SLOTS];
    t_meta       r_meta_rd;
    logic        meta_we, meta_re;
    t_ptr        meta_waddr, meta_raddr;
    t_meta       meta_wdata;

    logic        accept, out_free, end_of_packet;
    logic [31:0] age;
    t_ptr        rp_nx;
    t_off        off_new;
    logic [CMP_W-1:0] req_w, len_w, n_w;

    assign accept   = i_in_ch.valid && i_in_ch.ready;
    assign out_free = !r_ov || o_out_ch.ready;

    always_comb begin
        n_state  = r_state;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_slot   = r_slot;
        n_off    = r_off;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_req    = r_req;
        n_time   = r_time;
        n_pend   = r_pend;
        n_ov     = r_ov && !o_out_ch.ready;
        n_status = r_status;
        n_has    = r_has;
        n_byte   = r_byte;
        n_last   = r_last;
        n_occ    = r_occ;

        meta_we    = 1'b0;
        meta_waddr = r_wp;
        meta_wdata = '0;
        meta_re    = 1'b0;
        meta_raddr = r_rp;
        o_ram_req  = '0;

        age     = r_time - r_meta_rd.birth;
        rp_nx   = next_slot(r_rp);
        off_new = (r_off < OFF_W'(PACKET_BYTES)) ? r_off + 1'b1 : r_off;
        end_of_packet = ((r_cnt + 1'b1) == r_n);

        req_w = CMP_W'(r_req);
        len_w = CMP_W'(r_meta_rd.len);
        n_w   = (req_w < len_w) ? req_w : len_w;
        if (n_w > CMP_W'(MAX_RESULTS)) begin
            n_w = CMP_W'(MAX_RESULTS);
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_ch.opcode)
                        OP_TICK: begin
                            n_time = r_time + 1'b1;
                        end
                        OP_PUSH: begin
                            // Bytes past the slot size are dropped.
                            if (r_off < OFF_W'(PACKET_BYTES)) begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = byte_addr(r_wp, r_off);
                                o_ram_req.wdata = i_in_ch.data_byte;
                            end
                            n_off = off_new;
                            if (i_in_ch.last_byte) begin
                                if (next_slot(r_wp) == r_rp) begin
                                    n_pend = ST_FULL;
                                end else begin
                                    n_pend           = ST_OK;
                                    meta_we          = 1'b1;
                                    meta_wdata.len   = off_new;
                                    meta_wdata.birth = r_time;
                                    n_wp             = next_slot(r_wp);
                                end
                                n_off   = '0;
                                n_state = S_RESULT;
                            end
                        end
                        OP_POP: begin
                            n_req = i_in_ch.read_length;
                            if (r_rp == r_wp) begin
                                n_pend  = ST_EMPTY;
                                n_state = S_RESULT;
                            end else begin
                                meta_re = 1'b1;
                                n_state = S_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // Metadata of the head slot is valid this cycle.
                n_rp = rp_nx;
                if (age < i_lifetime) begin
                    if (n_w == '0) begin
                        n_pend  = ST_OK;
                        n_state = S_RESULT;
                    end else begin
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = byte_addr(r_rp, '0);
                        n_slot  = r_rp;
                        n_cnt   = '0;
                        n_n     = OFF_W'(n_w);
                        n_state = S_BOUT;
                    end
                end else if (rp_nx == r_wp) begin
                    n_pend  = ST_EMPTY;
                    n_state = S_RESULT;
                end else begin
                    meta_re    = 1'b1;
                    meta_raddr = rp_nx;
                end
            end
            S_BOUT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_status = ST_OK;
                    n_has    = 1'b1;
                    n_byte   = i_ram_rdata;
                    n_last   = end_of_packet;
                    n_occ    = occ_of(r_wp, r_rp);
                    n_cnt    = r_cnt + 1'b1;
                    if (end_of_packet) begin
                        n_state = S_IDLE;
                    end else begin
                        // Fetch the next byte while this one is taken.
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = byte_addr(r_slot, r_cnt + 1'b1);
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_status = r_pend;
                    n_has    = 1'b0;
                    n_byte   = 8'd0;
                    n_last   = 1'b1;
                    n_occ    = occ_of(r_wp, r_rp);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (meta_re) begin
            r_meta_rd <= meta_mem[meta_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_off   <= '0;
            r_time  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_off   <= n_off;
            r_time  <= n_time;
            r_ov    <= n_ov;
        end
        r_slot   <= n_slot;
        r_cnt    <= n_cnt;
        r_n      <= n_n;
        r_req    <= n_req;
        r_pend   <= n_pend;
        r_status <= n_status;
        r_has    <= n_has;
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_occ    <= n_occ;
    end

    assign i_in_ch.ready      = (r_state == S_IDLE);
    assign o_out_ch.valid     = r_ov;
    assign o_out_ch.status    = r_status;
    assign o_out_ch.has_data  = r_has;
    assign o_out_ch.out_byte  = r_byte;
    assign o_out_ch.last      = r_last;
    assign o_out_ch.occupancy = r_occ;

endmodule
